// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent check, also active while reset is high
`define RSAH_ASSERT(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("request_size_align_histogram: assertion failed");

// Concurrent check that is ignored while reset is high
`define RSAH_ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("request_size_align_histogram: assertion failed");

`endif

// File: hw/rtl/rsah_pkg.sv
package rsah_pkg;

   localparam int NUM_OPS       = 7;
   localparam int SIZE_BUCKETS  = 32;
   localparam int ALIGN_BUCKETS = 65;

   localparam int KIND_W = 2;
   localparam int OP_W   = 3;
   localparam int SIZE_W = 32;
   localparam int OFF_W  = 64;
   localparam int VAL_W  = 64;
   localparam int SB_W   = 5;
   localparam int AB_W   = 7;
   localparam int THR_W  = 7;

   localparam int COUNT_DEPTH = NUM_OPS * SIZE_BUCKETS * ALIGN_BUCKETS;
   localparam int BYTE_DEPTH  = NUM_OPS * SIZE_BUCKETS;
   localparam int COUNT_AW    = $clog2(COUNT_DEPTH);
   localparam int BYTE_AW     = $clog2(BYTE_DEPTH);
   localparam int TOT_AW      = $clog2(NUM_OPS);

   localparam int REQ_FIELDS_W = OP_W + SIZE_W + OFF_W + VAL_W + SB_W + AB_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = SB_W + AB_W + 1 + 3 * VAL_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_RECORD     = 2'd0,
      KIND_HIST_READ  = 2'd1,
      KIND_TOTAL_READ = 2'd2,
      KIND_NONE       = 2'd3
   } kind_type;

   // One classified item on its way from the front to the back
   typedef struct packed {
      kind_type             kind;
      logic [OP_W-1:0]      op;
      logic                 op_ok;
      logic [SB_W-1:0]      size_bucket;
      logic [AB_W-1:0]      align_bucket;
      logic                 hist_en;
      logic                 cnt_sel;
      logic                 byte_sel;
      logic [COUNT_AW-1:0]  cnt_addr;
      logic [BYTE_AW-1:0]   byte_addr;
      logic [SIZE_W-1:0]    size;
      logic [VAL_W-1:0]     latency;
   } entry_type;

endpackage

// File: hw/rtl/rsah_front.sv
module rsah_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [rsah_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [rsah_pkg::KIND_W-1:0]     req_tuser,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rsah_pkg::THR_W-1:0]      csr_wdata,
   input  logic                            clear_busy,
   output logic                            push_valid,
   input  logic                            push_ready,
   output rsah_pkg::entry_type             push_entry
);

   localparam int SIZE_LO = rsah_pkg::OP_W;
   localparam int OFF_LO  = SIZE_LO + rsah_pkg::SIZE_W;
   localparam int LAT_LO  = OFF_LO + rsah_pkg::OFF_W;
   localparam int QS_LO   = LAT_LO + rsah_pkg::VAL_W;
   localparam int QA_LO   = QS_LO + rsah_pkg::SB_W;

   function automatic logic [rsah_pkg::SB_W-1:0] msb_index(input logic [rsah_pkg::SIZE_W-1:0] v);
      logic [rsah_pkg::SIZE_W-1:0] s;
      logic [rsah_pkg::SIZE_W-1:0] hot;
      logic [rsah_pkg::SB_W-1:0]   idx;
      s   = v | (v >> 1);
      s   = s | (s >> 2);
      s   = s | (s >> 4);
      s   = s | (s >> 8);
      s   = s | (s >> 16);
      hot = s ^ (s >> 1);
      idx = '0;
      for (int i = 0; i < rsah_pkg::SIZE_W; i++) begin
         if (hot[i]) idx = idx | rsah_pkg::SB_W'(i);
      end
      return idx;
   endfunction

   function automatic logic [rsah_pkg::AB_W-1:0] tz_count(input logic [rsah_pkg::OFF_W-1:0] v);
      logic [rsah_pkg::OFF_W-1:0] hot;
      logic [rsah_pkg::AB_W-1:0]  idx;
      // isolate the lowest set bit, then encode its position
      hot = v & (~v + rsah_pkg::OFF_W'(1));
      idx = '0;
      for (int i = 0; i < rsah_pkg::OFF_W; i++) begin
         if (hot[i]) idx = idx | rsah_pkg::AB_W'(i);
      end
      if (v == '0) idx = rsah_pkg::AB_W'(rsah_pkg::OFF_W);
      return idx;
   endfunction

   logic [rsah_pkg::THR_W-1:0]      threshold_ff;
   logic                            hold_valid_ff;
   logic                            hold_valid_in;
   logic [rsah_pkg::REQ_DATA_W-1:0] hold_data_ff;
   rsah_pkg::kind_type              hold_kind_ff;

   logic                            req_take;
   logic [rsah_pkg::OP_W-1:0]       f_op;
   logic [rsah_pkg::SIZE_W-1:0]     f_size;
   logic [rsah_pkg::OFF_W-1:0]      f_offset;
   logic [rsah_pkg::VAL_W-1:0]      f_lat;
   logic [rsah_pkg::SB_W-1:0]       f_qs;
   logic [rsah_pkg::AB_W-1:0]       f_qa;
   logic [rsah_pkg::SB_W-1:0]       rec_sb;
   logic [rsah_pkg::AB_W-1:0]       rec_ab;
   logic [rsah_pkg::SB_W-1:0]       adr_sb;
   logic [rsah_pkg::AB_W-1:0]       adr_ab;
   logic                            op_ok;
   logic                            hist_en;
   logic                            q_cnt_ok;
   logic                            q_byte_ok;
   logic                            cnt_go;
   logic                            byte_go;
   int                              row;

   assign csr_ready  = 1'b1;
   assign req_tready = !clear_busy && (!hold_valid_ff || push_ready);
   assign req_take   = req_tvalid && req_tready;
   assign push_valid = hold_valid_ff;

   assign hold_valid_in = req_take ? 1'b1 : (push_ready ? 1'b0 : hold_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= rsah_pkg::THR_W'(95);
         hold_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) threshold_ff <= csr_wdata;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         hold_data_ff <= req_tdata;
         hold_kind_ff <= rsah_pkg::kind_type'(req_tuser);
      end
   end

   assign f_op     = hold_data_ff[rsah_pkg::OP_W-1:0];
   assign f_size   = hold_data_ff[SIZE_LO +: rsah_pkg::SIZE_W];
   assign f_offset = hold_data_ff[OFF_LO +: rsah_pkg::OFF_W];
   assign f_lat    = hold_data_ff[LAT_LO +: rsah_pkg::VAL_W];
   assign f_qs     = hold_data_ff[QS_LO +: rsah_pkg::SB_W];
   assign f_qa     = hold_data_ff[QA_LO +: rsah_pkg::AB_W];

   always_comb begin
      rec_sb = msb_index(f_size);
      rec_ab = tz_count(f_offset);
      if (int'(rec_sb) > rsah_pkg::SIZE_BUCKETS - 1)
         rec_sb = rsah_pkg::SB_W'(rsah_pkg::SIZE_BUCKETS - 1);
      if (int'(rec_ab) > rsah_pkg::ALIGN_BUCKETS - 1)
         rec_ab = rsah_pkg::AB_W'(rsah_pkg::ALIGN_BUCKETS - 1);

      op_ok     = int'(f_op) < rsah_pkg::NUM_OPS;
      hist_en   = (hold_kind_ff == rsah_pkg::KIND_RECORD) && op_ok
                  && (threshold_ff != '0) && (f_size != '0);
      q_byte_ok = op_ok && (int'(f_qs) < rsah_pkg::SIZE_BUCKETS);
      q_cnt_ok  = q_byte_ok && (int'(f_qa) < rsah_pkg::ALIGN_BUCKETS);

      adr_sb  = (hold_kind_ff == rsah_pkg::KIND_RECORD) ? rec_sb : f_qs;
      adr_ab  = (hold_kind_ff == rsah_pkg::KIND_RECORD) ? rec_ab : f_qa;
      cnt_go  = hist_en || ((hold_kind_ff == rsah_pkg::KIND_HIST_READ) && q_cnt_ok);
      byte_go = hist_en || ((hold_kind_ff == rsah_pkg::KIND_HIST_READ) && q_byte_ok);
      row     = int'(f_op) * rsah_pkg::SIZE_BUCKETS + int'(adr_sb);

      push_entry.kind     = hold_kind_ff;
      push_entry.op       = f_op;
      push_entry.op_ok    = op_ok;
      push_entry.hist_en  = hist_en;
      push_entry.cnt_sel  = q_cnt_ok;
      push_entry.byte_sel = q_byte_ok;
      push_entry.size     = f_size;
      push_entry.latency  = f_lat;
      // park unused lookups on entry zero so the address stays in range
      push_entry.cnt_addr  = cnt_go
                             ? rsah_pkg::COUNT_AW'(row * rsah_pkg::ALIGN_BUCKETS + int'(adr_ab))
                             : '0;
      push_entry.byte_addr = byte_go ? rsah_pkg::BYTE_AW'(row) : '0;

      unique case (hold_kind_ff)
         rsah_pkg::KIND_RECORD: begin
            push_entry.size_bucket  = rec_sb;
            push_entry.align_bucket = rec_ab;
         end
         rsah_pkg::KIND_HIST_READ, rsah_pkg::KIND_TOTAL_READ: begin
            push_entry.size_bucket  = f_qs;
            push_entry.align_bucket = f_qa;
         end
         default: begin
            push_entry.size_bucket  = '0;
            push_entry.align_bucket = '0;
         end
      endcase
   end

endmodule

// File: hw/rtl/rsah_queue.sv
module rsah_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  rsah_pkg::entry_type in_entry,
   output logic                out_valid,
   input  logic                out_ready,
   output rsah_pkg::entry_type out_entry
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsah_pkg::entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                push;
   logic                pop;

   assign in_ready  = count_ff != CNT_W'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_entry = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (int'(wr_ptr_ff) == DEPTH - 1) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (int'(rd_ptr_ff) == DEPTH - 1) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= in_entry;
   end

endmodule

// File: hw/rtl/rsah_back.sv
module rsah_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   output logic                            q_ready,
   input  rsah_pkg::entry_type             q_entry,
   output logic                            clear_busy,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rsah_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   localparam int VAL_W = rsah_pkg::VAL_W;

   state_type                       state_ff;
   logic [rsah_pkg::COUNT_AW-1:0]   clr_addr_ff;
   rsah_pkg::entry_type             cur_ff;
   logic                            rsp_valid_ff;
   logic [rsah_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [rsah_pkg::RSP_DATA_W-1:0] rsp_data_in;
   logic [VAL_W-1:0]                cnt_tot_ff  [rsah_pkg::NUM_OPS];
   logic [VAL_W-1:0]                byte_tot_ff [rsah_pkg::NUM_OPS];
   logic [VAL_W-1:0]                time_tot_ff [rsah_pkg::NUM_OPS];

   logic [VAL_W-1:0]                cnt_mem  [rsah_pkg::COUNT_DEPTH];
   logic [VAL_W-1:0]                byte_mem [rsah_pkg::BYTE_DEPTH];
   logic [VAL_W-1:0]                cnt_rd_ff;
   logic [VAL_W-1:0]                byte_rd_ff;

   logic                            rd_en;
   logic                            commit;
   logic                            tot_we;
   logic                            cnt_we;
   logic                            byte_we;
   logic [rsah_pkg::COUNT_AW-1:0]   cnt_waddr;
   logic [rsah_pkg::BYTE_AW-1:0]    byte_waddr;
   logic [VAL_W-1:0]                cnt_wdata;
   logic [VAL_W-1:0]                byte_wdata;
   logic [rsah_pkg::TOT_AW-1:0]     tot_idx;
   logic [VAL_W-1:0]                cnt_now;
   logic [VAL_W-1:0]                byte_now;
   logic [VAL_W-1:0]                time_now;
   logic [VAL_W-1:0]                cnt_new;
   logic [VAL_W-1:0]                byte_new;
   logic [VAL_W-1:0]                time_new;
   logic [VAL_W-1:0]                v_ops;
   logic [VAL_W-1:0]                v_bytes;
   logic [VAL_W-1:0]                v_time;
   logic                            upd;

   assign clear_busy = state_ff == ST_CLEAR;
   assign q_ready    = state_ff == ST_IDLE;
   assign rd_en      = q_valid && q_ready;
   assign commit     = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign tot_idx  = cur_ff.op_ok ? cur_ff.op : '0;
   assign cnt_now  = cnt_tot_ff[tot_idx];
   assign byte_now = byte_tot_ff[tot_idx];
   assign time_now = time_tot_ff[tot_idx];
   assign cnt_new  = cnt_now + VAL_W'(1);
   assign byte_new = byte_now + VAL_W'(cur_ff.size);
   assign time_new = time_now + cur_ff.latency;
   assign tot_we   = commit && (cur_ff.kind == rsah_pkg::KIND_RECORD) && cur_ff.op_ok;

   always_comb begin
      v_ops   = '0;
      v_bytes = '0;
      v_time  = '0;
      upd     = 1'b0;
      unique case (cur_ff.kind)
         rsah_pkg::KIND_RECORD: begin
            if (cur_ff.op_ok) begin
               v_ops   = cnt_new;
               v_bytes = byte_new;
               v_time  = time_new;
               upd     = cur_ff.hist_en;
            end
         end
         rsah_pkg::KIND_TOTAL_READ: begin
            if (cur_ff.op_ok) begin
               v_ops   = cnt_now;
               v_bytes = byte_now;
               v_time  = time_now;
            end
         end
         rsah_pkg::KIND_HIST_READ: begin
            if (cur_ff.op_ok) begin
               v_time  = time_now;
               v_bytes = cur_ff.byte_sel ? byte_rd_ff : '0;
               v_ops   = cur_ff.cnt_sel ? cnt_rd_ff : '0;
            end
         end
         default: begin
            v_ops = '0;
         end
      endcase
      rsp_data_in = rsah_pkg::RSP_DATA_W'({v_time, v_bytes, v_ops, upd,
                                           cur_ff.align_bucket, cur_ff.size_bucket});
   end

   // Write port: zero sweep after reset, else read-modify-write of the bins
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         cnt_we     = 1'b1;
         byte_we    = int'(clr_addr_ff) < rsah_pkg::BYTE_DEPTH;
         cnt_waddr  = clr_addr_ff;
         byte_waddr = clr_addr_ff[rsah_pkg::BYTE_AW-1:0];
         cnt_wdata  = '0;
         byte_wdata = '0;
      end else begin
         cnt_we     = commit && cur_ff.hist_en;
         byte_we    = commit && cur_ff.hist_en;
         cnt_waddr  = cur_ff.cnt_addr;
         byte_waddr = cur_ff.byte_addr;
         cnt_wdata  = cnt_rd_ff + VAL_W'(1);
         byte_wdata = byte_rd_ff + VAL_W'(cur_ff.size);
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
      if (rd_en) cnt_rd_ff <= cnt_mem[q_entry.cnt_addr];
   end

   always_ff @(posedge clock) begin
      if (byte_we) byte_mem[byte_waddr] <= byte_wdata;
      if (rd_en) byte_rd_ff <= byte_mem[q_entry.byte_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < rsah_pkg::NUM_OPS; i++) begin
            cnt_tot_ff[i]  <= '0;
            byte_tot_ff[i] <= '0;
            time_tot_ff[i] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_tready && !commit) rsp_valid_ff <= 1'b0;
         if (tot_we) begin
            cnt_tot_ff[tot_idx]  <= cnt_new;
            byte_tot_ff[tot_idx] <= byte_new;
            time_tot_ff[tot_idx] <= time_new;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + rsah_pkg::COUNT_AW'(1);
               if (clr_addr_ff == rsah_pkg::COUNT_AW'(rsah_pkg::COUNT_DEPTH - 1))
                  state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (q_valid) begin
                  cur_ff   <= q_entry;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               // hold until the output register is free
               if (commit) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= rsp_data_in;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// File: hw/rtl/request_size_align_histogram.sv
// Channel   Direction  Transfer when            Contents
// req_      in         req_tvalid & req_tready  tuser kind; tdata record or query
// rsp_      out        rsp_tvalid & rsp_tready  one result per request
// csr_      in         csr_valid & csr_ready    threshold_percent
//
// A request is held in the front register, then enters a two-entry queue. The back
// handles one item at a time (bin read, then update and result) and takes no new
// item until its result is in the output register, which drives rsp_tvalid. After
// reset the bin stores are swept to zero with req_tready low. A stalled result holds
// in the output register while the front keeps accepting until the queue and the
// front register are full.
module request_size_align_histogram (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // op_type, request length, req_offset, latency_us, query_size_bucket,
   // query_align_bucket, zero fill
   input  logic [rsah_pkg::REQ_DATA_W-1:0] req_tdata,
   // kind
   input  logic [rsah_pkg::KIND_W-1:0]     req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // size_bucket, align_bucket, hist_updated, ops_value, bytes_value,
   // time_value, zero fill
   output logic [rsah_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rsah_pkg::THR_W-1:0]      csr_wdata
);

   logic                clear_busy;
   logic                push_valid;
   logic                push_ready;
   rsah_pkg::entry_type push_entry;
   logic                pop_valid;
   logic                pop_ready;
   rsah_pkg::entry_type pop_entry;

   rsah_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .clear_busy (clear_busy),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   rsah_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_entry  (push_entry),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_entry (pop_entry)
   );

   rsah_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (pop_valid),
      .q_ready    (pop_ready),
      .q_entry    (pop_entry),
      .clear_busy (clear_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: hw/rtl/rsah_checker.sv
`include "assert_macros.svh"

module rsah_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rsah_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic rsp_stall;
   logic rsp_binned;

   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign rsp_binned = rsp_tvalid && rsp_tdata[12];

   // stalled result keeps its transfer intact
   `RSAH_ASSERT_RST(rsp_hold_a, clock, reset, rsp_stall |=> rsp_tvalid && $stable(rsp_tdata))

   // the zero sweep keeps the request side closed straight after reset
   `RSAH_ASSERT(req_closed_a, clock, reset |=> !req_tready)

   `RSAH_ASSERT(rsp_quiet_a, clock, reset |=> !rsp_tvalid)

   // a binned record has always been counted
   `RSAH_ASSERT_RST(upd_count_a, clock, reset, rsp_binned |-> rsp_tdata[76:13] != 64'd0)

endmodule

bind request_size_align_histogram rsah_checker u_rsah_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: tb/tb_top.sv
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [rsah_pkg::OP_W-1:0] OP_READ    = 3'd0;
   localparam logic [rsah_pkg::OP_W-1:0] OP_WRITE   = 3'd1;
   localparam logic [rsah_pkg::OP_W-1:0] OP_TRIM    = 3'd2;
   localparam logic [rsah_pkg::OP_W-1:0] OP_ZERO    = 3'd3;
   localparam logic [rsah_pkg::OP_W-1:0] OP_EXTENTS = 3'd4;
   localparam logic [rsah_pkg::OP_W-1:0] OP_CACHE   = 3'd5;
   localparam logic [rsah_pkg::OP_W-1:0] OP_FLUSH   = 3'd6;
   localparam logic [rsah_pkg::OP_W-1:0] OP_BAD     = 3'd7;

   localparam int unsigned STALL_LIMIT = 80000;
   localparam int unsigned HOLD_CYCLES = 300;

   // req_tdata layout, highest field first
   typedef struct packed {
      logic                          fill;
      logic [rsah_pkg::AB_W-1:0]     query_align;
      logic [rsah_pkg::SB_W-1:0]     query_size;
      logic [rsah_pkg::VAL_W-1:0]    latency;
      logic [rsah_pkg::OFF_W-1:0]    offset;
      logic [rsah_pkg::SIZE_W-1:0]   size;
      logic [rsah_pkg::OP_W-1:0]     op;
   } req_payload_type;

   // rsp_tdata layout, highest field first
   typedef struct packed {
      logic [2:0]                    fill;
      logic [rsah_pkg::VAL_W-1:0]    time_value;
      logic [rsah_pkg::VAL_W-1:0]    bytes_value;
      logic [rsah_pkg::VAL_W-1:0]    ops_value;
      logic                          hist_updated;
      logic [rsah_pkg::AB_W-1:0]     align_bucket;
      logic [rsah_pkg::SB_W-1:0]     size_bucket;
   } rsp_payload_type;

   typedef struct {
      logic [rsah_pkg::OP_W-1:0] op;
      int unsigned               size_bucket;
      int unsigned               align_bucket;
   } bin_key_type;

   class histogram_tracker;
      logic [rsah_pkg::THR_W-1:0] threshold;
      logic [rsah_pkg::VAL_W-1:0] op_count [rsah_pkg::NUM_OPS];
      logic [rsah_pkg::VAL_W-1:0] op_bytes [rsah_pkg::NUM_OPS];
      logic [rsah_pkg::VAL_W-1:0] op_latency [rsah_pkg::NUM_OPS];
      logic [rsah_pkg::VAL_W-1:0] bin_count [rsah_pkg::COUNT_DEPTH];
      logic [rsah_pkg::VAL_W-1:0] bin_bytes [rsah_pkg::BYTE_DEPTH];
      rsp_payload_type            expected_results [$];
      int unsigned                errors;

      function new();
         threshold = 7'd95;
         errors = 0;
         foreach (op_count[i]) begin
            op_count[i] = '0;
            op_bytes[i] = '0;
            op_latency[i] = '0;
         end
         foreach (bin_count[i]) bin_count[i] = '0;
         foreach (bin_bytes[i]) bin_bytes[i] = '0;
      endfunction

      function void note_request(rsah_pkg::kind_type kind, req_payload_type p);
         rsp_payload_type r;
         int unsigned     sb;
         int unsigned     ab;
         int unsigned     row;
         logic            op_ok;
         r = '0;
         sb = 0;
         ab = rsah_pkg::OFF_W;
         op_ok = (p.op < rsah_pkg::NUM_OPS);
         case (kind)
            rsah_pkg::KIND_RECORD: begin
               for (int i = 0; i < rsah_pkg::SIZE_W; i++) if (p.size[i]) sb = i;
               for (int i = rsah_pkg::OFF_W - 1; i >= 0; i--) if (p.offset[i]) ab = i;
               if (sb > rsah_pkg::SIZE_BUCKETS - 1) sb = rsah_pkg::SIZE_BUCKETS - 1;
               if (ab > rsah_pkg::ALIGN_BUCKETS - 1) ab = rsah_pkg::ALIGN_BUCKETS - 1;
               r.size_bucket = rsah_pkg::SB_W'(sb);
               r.align_bucket = rsah_pkg::AB_W'(ab);
               if (op_ok) begin
                  op_count[p.op] += 64'd1;
                  op_bytes[p.op] += rsah_pkg::VAL_W'(p.size);
                  op_latency[p.op] += p.latency;
                  if (threshold != '0 && p.size != '0) begin
                     row = int'(p.op) * rsah_pkg::SIZE_BUCKETS + sb;
                     bin_count[row * rsah_pkg::ALIGN_BUCKETS + ab] += 64'd1;
                     bin_bytes[row] += rsah_pkg::VAL_W'(p.size);
                     r.hist_updated = 1'b1;
                  end
                  r.ops_value = op_count[p.op];
                  r.bytes_value = op_bytes[p.op];
                  r.time_value = op_latency[p.op];
               end
            end
            rsah_pkg::KIND_HIST_READ, rsah_pkg::KIND_TOTAL_READ: begin
               r.size_bucket = p.query_size;
               r.align_bucket = p.query_align;
               if (op_ok) begin
                  r.time_value = op_latency[p.op];
                  if (kind == rsah_pkg::KIND_TOTAL_READ) begin
                     r.ops_value = op_count[p.op];
                     r.bytes_value = op_bytes[p.op];
                  end else if (p.query_size < rsah_pkg::SIZE_BUCKETS) begin
                     row = int'(p.op) * rsah_pkg::SIZE_BUCKETS + int'(p.query_size);
                     r.bytes_value = bin_bytes[row];
                     if (p.query_align < rsah_pkg::ALIGN_BUCKETS)
                        r.ops_value =
                           bin_count[row * rsah_pkg::ALIGN_BUCKETS + int'(p.query_align)];
                  end
               end
            end
            default: r = '0;
         endcase
         expected_results.push_back(r);
      endfunction

      function void compare_field(string name, logic [rsah_pkg::VAL_W-1:0] want,
                                  logic [rsah_pkg::VAL_W-1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, want, got);
         end
      endfunction

      function void check_response(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: result with nothing outstanding, expected none actual %h",
                     $realtime, got);
            return;
         end
         want = expected_results.pop_front();
         compare_field("size_bucket", rsah_pkg::VAL_W'(want.size_bucket),
                       rsah_pkg::VAL_W'(got.size_bucket));
         compare_field("align_bucket", rsah_pkg::VAL_W'(want.align_bucket),
                       rsah_pkg::VAL_W'(got.align_bucket));
         compare_field("hist_updated", rsah_pkg::VAL_W'(want.hist_updated),
                       rsah_pkg::VAL_W'(got.hist_updated));
         compare_field("ops_value", want.ops_value, got.ops_value);
         compare_field("bytes_value", want.bytes_value, got.bytes_value);
         compare_field("time_value", want.time_value, got.time_value);
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [rsah_pkg::REQ_DATA_W-1:0] req_tdata;
   logic [rsah_pkg::KIND_W-1:0]     req_tuser;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [rsah_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [rsah_pkg::THR_W-1:0]      csr_wdata;

   logic                            rsp_hold = 1'b0;
   bit                              pressure_go = 1'b0;
   int unsigned                     send_idle_pct = 11;
   int unsigned                     rsp_idle_pct = 56;
   int unsigned                     quiet_cycles = 0;
   bin_key_type                     recent_bins [$];
   histogram_tracker                book = new();

   request_size_align_histogram i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receive side: check each transfer, then pick the next ready level
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         book.check_response(rsp_payload_type'(rsp_tdata));
      if (rsp_hold) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Watchdog: count cycles with no transfer on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $realtime, quiet_cycles);
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Hold the receiver off long enough for the block to back up into its input
   initial begin
      wait (pressure_go);
      repeat (30) @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   function automatic req_payload_type make_payload(logic [rsah_pkg::OP_W-1:0] op,
                                                    logic [rsah_pkg::SIZE_W-1:0] size,
                                                    logic [rsah_pkg::OFF_W-1:0] offset,
                                                    logic [rsah_pkg::VAL_W-1:0] latency,
                                                    logic [rsah_pkg::SB_W-1:0] qs,
                                                    logic [rsah_pkg::AB_W-1:0] qa);
      req_payload_type p;
      p.fill = 1'b0;
      p.op = op;
      p.size = size;
      p.offset = offset;
      p.latency = latency;
      p.query_size = qs;
      p.query_align = qa;
      return p;
   endfunction

   task automatic send_request(rsah_pkg::kind_type kind, req_payload_type p);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= p;
      do @(posedge clock); while (!req_tready);
      book.note_request(kind, p);
   endtask

   task automatic write_threshold(logic [rsah_pkg::THR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      book.threshold = value;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (book.expected_results.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic run_random(int unsigned count);
      req_payload_type    p;
      rsah_pkg::kind_type kind;
      bin_key_type        key;
      int unsigned        pick;
      int unsigned        sb;
      int unsigned        ab;
      logic [31:0]        mask;
      for (int unsigned n = 0; n < count; n++) begin
         p = make_payload(rsah_pkg::OP_W'($urandom_range(OP_READ, OP_FLUSH)), $urandom,
                          {$urandom, $urandom}, {$urandom, $urandom},
                          rsah_pkg::SB_W'($urandom_range(0, 31)),
                          rsah_pkg::AB_W'($urandom_range(0, 127)));
         if ($urandom_range(99) < 8) p.op = OP_BAD;
         pick = $urandom_range(99);
         if (pick < 55) begin
            kind = rsah_pkg::KIND_RECORD;
            sb = $urandom_range(0, 31);
            mask = (sb == 0) ? 32'd0 : (32'hFFFF_FFFF >> (32 - sb));
            pick = $urandom_range(99);
            // mostly steer the size into a chosen bucket, keep some zero and raw sizes
            if (pick < 5) p.size = '0;
            else if (pick >= 10) p.size = (32'd1 << sb) | (p.size & mask);
            ab = ($urandom_range(99) < 70) ? 3 * $urandom_range(0, 4) : $urandom_range(0, 63);
            if ($urandom_range(99) < 6) ab = 64;
            p.offset = (ab == 64) ? '0 : ((p.offset | 64'd1) << ab);
            if ($urandom_range(99) < 30) p.latency = p.latency >> $urandom_range(1, 63);
            key.op = p.op;
            key.size_bucket = sb;
            key.align_bucket = ab;
            recent_bins.push_back(key);
            if (recent_bins.size() > 16) void'(recent_bins.pop_front());
         end else if (pick < 80) begin
            kind = rsah_pkg::KIND_HIST_READ;
            // read back a bin that was recently hit most of the time
            if (recent_bins.size() != 0 && $urandom_range(99) < 70) begin
               key = recent_bins[$urandom_range(0, recent_bins.size() - 1)];
               p.op = key.op;
               p.query_size = rsah_pkg::SB_W'(key.size_bucket);
               p.query_align = rsah_pkg::AB_W'(key.align_bucket);
            end
         end else if (pick < 95) begin
            kind = rsah_pkg::KIND_TOTAL_READ;
         end else begin
            kind = rsah_pkg::KIND_NONE;
         end
         send_request(kind, p);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = rsah_pkg::KIND_RECORD;
      csr_valid = 1'b0;
      csr_wdata = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      write_threshold(7'd100);
      send_request(rsah_pkg::KIND_RECORD,
                   make_payload(OP_READ, 32'd0, 64'd0, 64'd0, 5'd0, 7'd0));
      send_request(rsah_pkg::KIND_RECORD,
                   make_payload(OP_READ, 32'd1, 64'd1, 64'd1, 5'd31, 7'd127));
      // two full-scale latencies wrap the time total
      send_request(rsah_pkg::KIND_RECORD, make_payload(OP_READ, '1, 64'd0, '1, 5'd0, 7'd0));
      send_request(rsah_pkg::KIND_RECORD, make_payload(OP_READ, '1, 64'd0, '1, 5'd0, 7'd0));
      send_request(rsah_pkg::KIND_RECORD,
                   make_payload(OP_FLUSH, 32'h8000_0000, 64'h8000_0000_0000_0000,
                                64'd5, 5'd0, 7'd0));
      send_request(rsah_pkg::KIND_RECORD,
                   make_payload(OP_FLUSH, 32'd4096, '1, 64'd0, 5'd0, 7'd0));
      send_request(rsah_pkg::KIND_RECORD,
                   make_payload(OP_BAD, 32'd100, 64'd8, 64'd9, 5'd0, 7'd0));
      send_request(rsah_pkg::KIND_RECORD,
                   make_payload(OP_WRITE, 32'd512, 64'h200, 64'd7, 5'd0, 7'd0));
      send_request(rsah_pkg::KIND_RECORD,
                   make_payload(OP_TRIM, 32'd3, 64'h30, 64'd2, 5'd0, 7'd0));
      send_request(rsah_pkg::KIND_RECORD,
                   make_payload(OP_ZERO, 32'd65536, 64'h1_0000, 64'd3, 5'd0, 7'd0));
      send_request(rsah_pkg::KIND_RECORD,
                   make_payload(OP_EXTENTS, 32'd7, 64'd5, 64'd4, 5'd0, 7'd0));
      send_request(rsah_pkg::KIND_RECORD,
                   make_payload(OP_CACHE, 32'd1024, 64'd0, 64'd6, 5'd0, 7'd0));
      send_request(rsah_pkg::KIND_HIST_READ, make_payload(OP_READ, '1, '1, '1, 5'd31, 7'd64));
      send_request(rsah_pkg::KIND_HIST_READ, make_payload(OP_READ, '0, '0, '0, 5'd0, 7'd0));
      send_request(rsah_pkg::KIND_HIST_READ,
                   make_payload(OP_FLUSH, 32'd0, 64'd0, 64'd0, 5'd31, 7'd63));
      send_request(rsah_pkg::KIND_HIST_READ,
                   make_payload(OP_FLUSH, 32'd0, 64'd0, 64'd0, 5'd12, 7'd64));
      // align query past the last bucket
      send_request(rsah_pkg::KIND_HIST_READ,
                   make_payload(OP_READ, 32'd0, 64'd0, 64'd0, 5'd31, 7'd65));
      send_request(rsah_pkg::KIND_HIST_READ,
                   make_payload(OP_READ, 32'd0, 64'd0, 64'd0, 5'd31, 7'd127));
      send_request(rsah_pkg::KIND_HIST_READ,
                   make_payload(OP_BAD, 32'd0, 64'd0, 64'd0, 5'd6, 7'd3));
      send_request(rsah_pkg::KIND_TOTAL_READ,
                   make_payload(OP_READ, '1, '1, '1, 5'd31, 7'd127));
      send_request(rsah_pkg::KIND_TOTAL_READ,
                   make_payload(OP_FLUSH, 32'd0, 64'd0, 64'd0, 5'd0, 7'd0));
      send_request(rsah_pkg::KIND_TOTAL_READ,
                   make_payload(OP_BAD, 32'd0, 64'd0, 64'd0, 5'd0, 7'd0));
      send_request(rsah_pkg::KIND_NONE, make_payload(OP_BAD, '1, '1, '1, 5'd31, 7'd127));

      drain_results();
      write_threshold(7'd0);
      run_random(100);

      drain_results();
      write_threshold(7'd127);
      run_random(200);

      send_idle_pct = 56;
      rsp_idle_pct = 11;
      drain_results();
      write_threshold(7'd1);
      run_random(300);

      send_idle_pct = 0;
      rsp_idle_pct = 0;
      drain_results();
      write_threshold(7'd95);
      pressure_go = 1'b1;
      run_random(300);

      drain_results();
      if (book.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
